/* sv/i2cadc_pkg.sv */
// Shared types and constants for the I2C converter read sequencer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package i2cadc_pkg;

   // Timer width default for the phase counter
   localparam int TIMER_WIDTH_DEF = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADC_SETUP_BYTE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_RETRY_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD_TICKS = 2'd3;
   localparam int CSR_DATA_WIDTH = 16;

   // Configuration reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'h48;
   localparam logic [7:0]  ADC_SETUP_BYTE_RST    = 8'h84;
   localparam logic [7:0]  ACK_RETRY_LIMIT_RST   = 8'd20;
   localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd50;

   // Bus direction bits appended to the address
   localparam logic BUS_WRITE = 1'b0;
   localparam logic BUS_READ  = 1'b1;

   // Saturation point of the poll counter
   localparam logic [7:0] RETRY_MAX = 8'hFF;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [7:0]  adc_setup_byte;
      logic [7:0]  ack_retry_limit;
      logic [15:0] half_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_enable;
      logic        sda_level;
      logic        busy_res;
      logic        done_res;
      logic [15:0] sample_word;
      logic [7:0]  readback_byte;
      logic        ack_missing;
   } rsp_type;

endpackage

/* sv/i2cadc_csr.sv */
// Configuration registers of the I2C converter read sequencer.
// Depends on i2cadc_pkg for register indexes, reset values and cfg_type.
`timescale 1ns / 1ps

module i2cadc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [i2cadc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cadc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output i2cadc_pkg::cfg_type                    cfg
);

   i2cadc_pkg::cfg_type cfg_ff;
   i2cadc_pkg::cfg_type cfg_in;

   // Update the addressed register on a transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            i2cadc_pkg::CSR_DEVICE_ADDRESS:    cfg_in.device_address    = csr_data[6:0];
            i2cadc_pkg::CSR_ADC_SETUP_BYTE:    cfg_in.adc_setup_byte    = csr_data[7:0];
            i2cadc_pkg::CSR_ACK_RETRY_LIMIT:   cfg_in.ack_retry_limit   = csr_data[7:0];
            i2cadc_pkg::CSR_HALF_PERIOD_TICKS: cfg_in.half_period_ticks = csr_data;
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= i2cadc_pkg::DEVICE_ADDRESS_RST;
         cfg_ff.adc_setup_byte    <= i2cadc_pkg::ADC_SETUP_BYTE_RST;
         cfg_ff.ack_retry_limit   <= i2cadc_pkg::ACK_RETRY_LIMIT_RST;
         cfg_ff.half_period_ticks <= i2cadc_pkg::HALF_PERIOD_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/i2cadc_core.sv */
// Bus sequencer of the I2C converter read cycle: one tick per step enable.
// Depends on i2cadc_pkg for cfg_type, rsp_type and constants.
`timescale 1ns / 1ps

module i2cadc_core #(
   parameter int TIMER_WIDTH = i2cadc_pkg::TIMER_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                req_type,
   input  logic                sda_in,
   input  i2cadc_pkg::cfg_type cfg,
   output i2cadc_pkg::rsp_type rsp
);

   // Compare width covers both the timer and the 16-bit half period
   localparam int CMP_WIDTH = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WSTART, ST_WADDR, ST_WPOLL1, ST_WSETUP, ST_WPOLL2, ST_WSTOP,
      ST_RSTART, ST_RADDR, ST_RPOLL, ST_RB0, ST_RA0, ST_RB1, ST_RA1, ST_RB2,
      ST_RN2, ST_RSTOP
   } step_type;

   step_type               step_ff, step_in;
   logic [3:0]             bit_ff, bit_in;
   logic                   half_ff, half_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [7:0]             retry_ff, retry_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             high_ff, high_in;
   logic [7:0]             low_ff, low_in;
   logic [7:0]             status_ff, status_in;
   logic                   fail_ff, fail_in;

   logic [15:0]          half_m1;
   logic [CMP_WIDTH-1:0] last_phase;
   logic [CMP_WIDTH-1:0] timer_mask;
   logic [7:0]           retry_lim;
   logic                 scl_lv, en_lv, sda_lv, busy, done;

   // Last tick index of a phase, saturated to the timer range
   always_comb begin
      half_m1    = (cfg.half_period_ticks == 16'd0) ? 16'd0 : cfg.half_period_ticks - 16'd1;
      timer_mask = CMP_WIDTH'({TIMER_WIDTH{1'b1}});
      last_phase = (CMP_WIDTH'(half_m1) > timer_mask) ? timer_mask : CMP_WIDTH'(half_m1);
      retry_lim  = (cfg.ack_retry_limit == 8'd0) ? 8'd1 : cfg.ack_retry_limit;
   end

   // One tick: start on request, drive lines, time the phase, advance
   always_comb begin
      step_in   = step_ff;
      bit_in    = bit_ff;
      half_in   = half_ff;
      timer_in  = timer_ff;
      retry_in  = retry_ff;
      shift_in  = shift_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      status_in = status_ff;
      fail_in   = fail_ff;
      done      = 1'b0;

      if (step_ff == ST_IDLE && req_type) begin
         step_in  = ST_WSTART;
         bit_in   = 4'd0;
         half_in  = 1'b0;
         shift_in = 8'd0;
         retry_in = 8'd0;
         timer_in = '0;
         fail_in  = 1'b0;
      end

      // Line levels of the current phase
      case (step_in)
         ST_WSTART, ST_RSTART: begin
            scl_lv = (bit_in < 4'd2);
            en_lv  = 1'b1;
            sda_lv = (bit_in == 4'd0);
         end
         ST_WSTOP, ST_RSTOP: begin
            scl_lv = (bit_in != 4'd0);
            en_lv  = 1'b1;
            sda_lv = (bit_in >= 4'd2);
         end
         ST_WADDR, ST_WSETUP, ST_RADDR: begin
            scl_lv = half_in;
            en_lv  = 1'b1;
            sda_lv = shift_in[7];
         end
         ST_RA0, ST_RA1: begin
            scl_lv = half_in;
            en_lv  = 1'b1;
            sda_lv = 1'b0;
         end
         ST_RN2: begin
            scl_lv = half_in;
            en_lv  = 1'b1;
            sda_lv = 1'b1;
         end
         ST_WPOLL1, ST_WPOLL2, ST_RPOLL, ST_RB0, ST_RB1, ST_RB2: begin
            scl_lv = half_in;
            en_lv  = 1'b0;
            sda_lv = 1'b0;
         end
         default: begin
            scl_lv = 1'b0;
            en_lv  = 1'b1;
            sda_lv = 1'b1;
         end
      endcase

      busy = (step_in != ST_IDLE);

      if (busy) begin
         if (CMP_WIDTH'(timer_in) >= last_phase) begin
            timer_in = '0;
            if (step_in == ST_WSTART || step_in == ST_RSTART ||
                step_in == ST_WSTOP || step_in == ST_RSTOP) begin
               // Three fixed sub-phases, then hand over
               if (bit_in < 4'd2) begin
                  bit_in = bit_in + 4'd1;
               end else begin
                  bit_in   = 4'd0;
                  half_in  = 1'b0;
                  retry_in = 8'd0;
                  shift_in = 8'd0;
                  case (step_in)
                     ST_WSTART: begin
                        step_in  = ST_WADDR;
                        shift_in = {cfg.device_address, i2cadc_pkg::BUS_WRITE};
                     end
                     ST_RSTART: begin
                        step_in  = ST_RADDR;
                        shift_in = {cfg.device_address, i2cadc_pkg::BUS_READ};
                     end
                     ST_WSTOP: step_in = ST_RSTART;
                     default: begin
                        step_in = ST_IDLE;
                        done    = 1'b1;
                     end
                  endcase
               end
            end else if (!half_in) begin
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               case (step_in)
                  // Transmit: shift out MSB first
                  ST_WADDR, ST_WSETUP, ST_RADDR: begin
                     shift_in = {shift_in[6:0], 1'b0};
                     bit_in   = bit_in + 4'd1;
                     if (bit_in >= 4'd8) begin
                        bit_in   = 4'd0;
                        retry_in = 8'd0;
                        shift_in = 8'd0;
                        step_in  = (step_in == ST_WADDR) ? ST_WPOLL1 :
                                   ((step_in == ST_WSETUP) ? ST_WPOLL2 : ST_RPOLL);
                     end
                  end
                  // Poll: repeat while SDA high, up to the limit
                  ST_WPOLL1, ST_WPOLL2, ST_RPOLL: begin
                     if (retry_in != i2cadc_pkg::RETRY_MAX) begin
                        retry_in = retry_in + 8'd1;
                     end
                     if (!(sda_in && retry_in < retry_lim)) begin
                        if (sda_in) begin
                           fail_in = 1'b1;
                        end
                        bit_in   = 4'd0;
                        retry_in = 8'd0;
                        shift_in = 8'd0;
                        if (step_in == ST_WPOLL1) begin
                           step_in  = ST_WSETUP;
                           shift_in = cfg.adc_setup_byte;
                        end else if (step_in == ST_WPOLL2) begin
                           step_in = ST_WSTOP;
                        end else begin
                           step_in = ST_RB0;
                        end
                     end
                  end
                  // Receive: shift in MSB first, store on the eighth bit
                  ST_RB0, ST_RB1, ST_RB2: begin
                     shift_in = {shift_in[6:0], sda_in};
                     bit_in   = bit_in + 4'd1;
                     if (bit_in >= 4'd8) begin
                        if (step_in == ST_RB0) begin
                           high_in = shift_in;
                           step_in = ST_RA0;
                        end else if (step_in == ST_RB1) begin
                           low_in  = shift_in;
                           step_in = ST_RA1;
                        end else begin
                           status_in = shift_in;
                           step_in   = ST_RN2;
                        end
                        bit_in   = 4'd0;
                        retry_in = 8'd0;
                        shift_in = 8'd0;
                     end
                  end
                  ST_RA0: step_in = ST_RB1;
                  ST_RA1: step_in = ST_RB2;
                  ST_RN2: step_in = ST_RSTOP;
                  default: begin
                     step_in  = ST_IDLE;
                     bit_in   = 4'd0;
                     retry_in = 8'd0;
                     shift_in = 8'd0;
                  end
               endcase
            end
         end else begin
            timer_in = timer_in + 1'b1;
         end
      end
   end

   // Hold sequencer state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_IDLE;
         bit_ff    <= 4'd0;
         half_ff   <= 1'b0;
         timer_ff  <= '0;
         retry_ff  <= 8'd0;
         shift_ff  <= 8'd0;
         high_ff   <= 8'd0;
         low_ff    <= 8'd0;
         status_ff <= 8'd0;
         fail_ff   <= 1'b0;
      end else if (step_en) begin
         step_ff   <= step_in;
         bit_ff    <= bit_in;
         half_ff   <= half_in;
         timer_ff  <= timer_in;
         retry_ff  <= retry_in;
         shift_ff  <= shift_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         status_ff <= status_in;
         fail_ff   <= fail_in;
      end
   end

   always_comb begin
      rsp.scl_level     = scl_lv;
      rsp.sda_enable    = en_lv;
      rsp.sda_level     = sda_lv;
      rsp.busy_res      = busy;
      rsp.done_res      = done;
      rsp.sample_word   = done ? {high_in, low_in} : 16'd0;
      rsp.readback_byte = done ? status_in : 8'd0;
      rsp.ack_missing   = done ? fail_in : 1'b0;
   end

   // A finishing tick returns the sequencer to idle
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> step_ff == ST_IDLE)
      else $error("sequencer not idle after done");

   // Done only comes on a busy tick
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      step_en && done |-> busy)
      else $error("done without busy");

   // Bit counter never passes one byte
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8)
      else $error("bit counter out of range");

   // Poll count is only kept inside a poll
   a_retry_in_poll: assert property (@(posedge clock) disable iff (reset)
      retry_ff != 8'd0 |->
         (step_ff == ST_WPOLL1 || step_ff == ST_WPOLL2 || step_ff == ST_RPOLL))
      else $error("retry count outside poll");

   // Start and stop phases never use the half-period bit
   a_half_clear: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_WSTART || step_ff == ST_RSTART ||
       step_ff == ST_WSTOP || step_ff == ST_RSTOP || step_ff == ST_IDLE) |-> !half_ff)
      else $error("half bit set in start, stop or idle");

endmodule

/* sv/i2c_adc_read_sequencer.sv */
// I2C converter read sequencer. Each transfer is one bus tick; one result per tick.
// Path: a tick is held in the input register, then stepped into the result register
// once that register is empty or being drained, and transfers out from there.
// Throughput: one tick per cycle unless rsp_stall holds a full result register.
// Reset (synchronous, active high): sequencer idle, received bytes cleared,
// configuration at its defaults, both registers empty.
`timescale 1ns / 1ps

module i2c_adc_read_sequencer #(
   parameter int TIMER_WIDTH = i2cadc_pkg::TIMER_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic                                   req_sda_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_scl_level,
   output logic                                   rsp_sda_enable,
   output logic                                   rsp_sda_level,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic [15:0]                            rsp_sample_word,
   output logic [7:0]                             rsp_readback_byte,
   output logic                                   rsp_ack_missing,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [i2cadc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cadc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   i2cadc_pkg::cfg_type cfg;
   i2cadc_pkg::rsp_type rsp_next;
   i2cadc_pkg::rsp_type out_ff;

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic in_type_ff, in_sda_ff;
   logic req_accept, step_en;

   assign csr_ready = 1'b1;

   i2cadc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Step when the result register is free or being drained
   assign step_en    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_en;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (step_en) begin
         out_valid_in = 1'b1;
      end
   end

   i2cadc_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req_type (in_type_ff),
      .sda_in   (in_sda_ff),
      .cfg      (cfg),
      .rsp      (rsp_next)
   );

   // Track occupancy of both registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_type;
         in_sda_ff  <= req_sda_in;
      end
      if (step_en) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_scl_level     = out_ff.scl_level;
   assign rsp_sda_enable    = out_ff.sda_enable;
   assign rsp_sda_level     = out_ff.sda_level;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_sample_word   = out_ff.sample_word;
   assign rsp_readback_byte = out_ff.readback_byte;
   assign rsp_ack_missing   = out_ff.ack_missing;

endmodule

/* tb/i2c_adc_read_sequencer_test.sv */
// Self-checking testbench for the I2C converter read sequencer: drives bus ticks and
// configuration writes, predicts every per-tick result and compares it field by field.
// Depends on i2cadc_pkg and the i2c_adc_read_sequencer top level.
`timescale 1ns / 1ps

module i2c_adc_read_sequencer_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_TICK_GOAL = 100;
   localparam int LONG_PHASE_TICKS = 40;
   localparam int REPORT_CAP = 100;

   // Bus sequence steps, in transfer order
   typedef enum logic [4:0] {
      BUS_IDLE, W_START, W_ADDR, W_ACK, W_SETUP, W_ACK2, W_STOP,
      R_START, R_ADDR, R_ACK, R_BYTE0, R_MACK0, R_BYTE1, R_MACK1,
      R_BYTE2, R_NACK2, R_STOP
   } bus_step_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_type = 1'b0;
   logic                                   req_sda_in = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic                                   rsp_scl_level;
   logic                                   rsp_sda_enable;
   logic                                   rsp_sda_level;
   logic                                   rsp_busy_res;
   logic                                   rsp_done_res;
   logic [15:0]                            rsp_sample_word;
   logic [7:0]                             rsp_readback_byte;
   logic                                   rsp_ack_missing;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [i2cadc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [i2cadc_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   i2c_adc_read_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scl_level(rsp_scl_level), .rsp_sda_enable(rsp_sda_enable),
      .rsp_sda_level(rsp_sda_level), .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res), .rsp_sample_word(rsp_sample_word),
      .rsp_readback_byte(rsp_readback_byte), .rsp_ack_missing(rsp_ack_missing),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Sequencer shadow state and configuration, at reset values
   i2cadc_pkg::cfg_type bus_cfg = '{i2cadc_pkg::DEVICE_ADDRESS_RST,
                                    i2cadc_pkg::ADC_SETUP_BYTE_RST,
                                    i2cadc_pkg::ACK_RETRY_LIMIT_RST,
                                    i2cadc_pkg::HALF_PERIOD_TICKS_RST};
   bus_step_type seq_step = BUS_IDLE;
   logic [3:0]  seq_bits = '0;
   logic [15:0] seq_timer = '0;
   logic [7:0]  seq_polls = '0;
   logic [7:0]  seq_shift = '0;
   logic [7:0]  rx_high = '0;
   logic [7:0]  rx_low = '0;
   logic [7:0]  rx_status = '0;
   logic        seq_nak = 1'b0;
   logic        seq_half = 1'b0;

   i2cadc_pkg::rsp_type expected_lines[$];

   int tx_gap_pct = 0;
   int rx_stall_pct = 0;
   int n_errors = 0;
   int n_ticks = 0;
   int n_reads = 0;
   int n_done = 0;
   int n_exhausted = 0;
   int n_cycles = 0;

   function automatic void enter_step(bus_step_type s, logic [7:0] b);
      seq_step = s;
      seq_bits = '0;
      seq_half = 1'b0;
      seq_shift = b;
      seq_polls = '0;
   endfunction

   // SCL, SDA enable and SDA level for the current step
   function automatic logic [2:0] line_drive();
      case (seq_step)
         W_START, R_START:
            return (seq_bits == 0) ? 3'b111 : ((seq_bits == 1) ? 3'b110 : 3'b010);
         W_STOP, R_STOP:
            return (seq_bits == 0) ? 3'b010 : ((seq_bits == 1) ? 3'b110 : 3'b111);
         W_ADDR, W_SETUP, R_ADDR: return {seq_half, 1'b1, seq_shift[7]};
         R_MACK0, R_MACK1:        return {seq_half, 2'b10};
         R_NACK2:                 return {seq_half, 2'b11};
         W_ACK, W_ACK2, R_ACK, R_BYTE0, R_BYTE1, R_BYTE2:
            return {seq_half, 2'b00};
         default:                 return 3'b011;
      endcase
   endfunction

   // End of one bus phase; returns 1 when the read cycle completes
   function automatic bit close_phase(logic sd);
      logic [7:0] lim;
      lim = (bus_cfg.ack_retry_limit == 8'd0) ? 8'd1 : bus_cfg.ack_retry_limit;
      case (seq_step)
         W_START, R_START, W_STOP, R_STOP: begin
            if (seq_bits < 2) begin
               seq_bits++;
               return 1'b0;
            end
            case (seq_step)
               W_START: enter_step(W_ADDR, {bus_cfg.device_address, i2cadc_pkg::BUS_WRITE});
               R_START: enter_step(R_ADDR, {bus_cfg.device_address, i2cadc_pkg::BUS_READ});
               W_STOP:  enter_step(R_START, 8'h00);
               default: begin
                  enter_step(BUS_IDLE, 8'h00);
                  return 1'b1;
               end
            endcase
            return 1'b0;
         end
         default: ;
      endcase
      // bit-level phases: low half first, then high half
      if (!seq_half) begin
         seq_half = 1'b1;
         return 1'b0;
      end
      seq_half = 1'b0;
      case (seq_step)
         W_ADDR, W_SETUP, R_ADDR: begin
            seq_shift = seq_shift << 1;
            seq_bits++;
            if (seq_bits >= 8) begin
               case (seq_step)
                  W_ADDR:  enter_step(W_ACK, 8'h00);
                  W_SETUP: enter_step(W_ACK2, 8'h00);
                  default: enter_step(R_ACK, 8'h00);
               endcase
            end
         end
         W_ACK, W_ACK2, R_ACK: begin
            if (seq_polls != i2cadc_pkg::RETRY_MAX) seq_polls++;
            if (sd && seq_polls < lim) return 1'b0;
            if (sd) begin
               seq_nak = 1'b1;
               n_exhausted++;
            end
            case (seq_step)
               W_ACK:   enter_step(W_SETUP, bus_cfg.adc_setup_byte);
               W_ACK2:  enter_step(W_STOP, 8'h00);
               default: enter_step(R_BYTE0, 8'h00);
            endcase
         end
         R_BYTE0, R_BYTE1, R_BYTE2: begin
            seq_shift = {seq_shift[6:0], sd};
            seq_bits++;
            if (seq_bits >= 8) begin
               case (seq_step)
                  R_BYTE0: begin
                     rx_high = seq_shift;
                     enter_step(R_MACK0, 8'h00);
                  end
                  R_BYTE1: begin
                     rx_low = seq_shift;
                     enter_step(R_MACK1, 8'h00);
                  end
                  default: begin
                     rx_status = seq_shift;
                     enter_step(R_NACK2, 8'h00);
                  end
               endcase
            end
         end
         R_MACK0: enter_step(R_BYTE1, 8'h00);
         R_MACK1: enter_step(R_BYTE2, 8'h00);
         R_NACK2: enter_step(R_STOP, 8'h00);
         default: enter_step(BUS_IDLE, 8'h00);
      endcase
      return 1'b0;
   endfunction

   // Advance the shadow sequencer by one tick and form its result
   function automatic i2cadc_pkg::rsp_type predict_tick(logic rq, logic sd);
      i2cadc_pkg::rsp_type r;
      logic [2:0]  lv;
      logic [15:0] last;
      bit          fin;
      r = '0;
      fin = 1'b0;
      if (seq_step == BUS_IDLE && rq) begin
         enter_step(W_START, 8'h00);
         seq_timer = '0;
         seq_nak = 1'b0;
      end
      lv = line_drive();
      if (seq_step != BUS_IDLE) begin
         r.busy_res = 1'b1;
         last = (bus_cfg.half_period_ticks == 16'd0) ? 16'd0 :
                bus_cfg.half_period_ticks - 16'd1;
         if (seq_timer >= last) begin
            seq_timer = '0;
            fin = close_phase(sd);
         end else begin
            seq_timer = seq_timer + 16'd1;
         end
      end
      {r.scl_level, r.sda_enable, r.sda_level} = lv;
      r.done_res = fin;
      if (fin) begin
         r.sample_word = {rx_high, rx_low};
         r.readback_byte = rx_status;
         r.ack_missing = seq_nak;
         n_done++;
      end
      return r;
   endfunction

   // Present one tick, hold it until transfer, then record its expected result
   task automatic send_tick(input logic rq, input logic sd);
      while ($urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rq;
      req_sda_in <= sd;
      do @(posedge clock); while (req_stall);
      expected_lines.push_back(predict_tick(rq, sd));
      n_ticks++;
   endtask

   // Drop valid and wait until every result has arrived
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the pipeline is empty
   task automatic load_config(input logic [6:0] addr, input logic [7:0] setup,
                              input logic [7:0] retry, input logic [15:0] half);
      logic [i2cadc_pkg::CSR_INDEX_WIDTH-1:0] wr_index [4];
      logic [i2cadc_pkg::CSR_DATA_WIDTH-1:0]  wr_data [4];
      settle_pipeline();
      wr_index[0] = i2cadc_pkg::CSR_DEVICE_ADDRESS;
      wr_index[1] = i2cadc_pkg::CSR_ADC_SETUP_BYTE;
      wr_index[2] = i2cadc_pkg::CSR_ACK_RETRY_LIMIT;
      wr_index[3] = i2cadc_pkg::CSR_HALF_PERIOD_TICKS;
      wr_data[0] = {9'd0, addr};
      wr_data[1] = {8'd0, setup};
      wr_data[2] = {8'd0, retry};
      wr_data[3] = half;
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= wr_index[k];
         csr_data <= wr_data[k];
         do @(posedge clock); while (!csr_ready);
         case (wr_index[k])
            i2cadc_pkg::CSR_DEVICE_ADDRESS:
               bus_cfg.device_address = wr_data[k][6:0];
            i2cadc_pkg::CSR_ADC_SETUP_BYTE:
               bus_cfg.adc_setup_byte = wr_data[k][7:0];
            i2cadc_pkg::CSR_ACK_RETRY_LIMIT:
               bus_cfg.ack_retry_limit = wr_data[k][7:0];
            default:
               bus_cfg.half_period_ticks = wr_data[k];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // One full read cycle from idle back to idle; ack_pct biases SDA low in polls
   task automatic run_read(input int ack_pct, input int busy_req_pct);
      logic in_poll;
      logic sd;
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      while (seq_step != BUS_IDLE) begin
         in_poll = (seq_step == W_ACK || seq_step == W_ACK2 || seq_step == R_ACK);
         sd = in_poll ? ($urandom_range(0, 99) >= ack_pct) : 1'($urandom_range(0, 1));
         send_tick($urandom_range(0, 99) < busy_req_pct, sd);
      end
      n_reads++;
   endtask

   task automatic check_idle_lines();
      for (int k = 0; k < 12; k++) send_tick(1'b0, k[0]);
   endtask

   task automatic check_clean_read();
      load_config(7'h7F, 8'h00, 8'd1, 16'd1);
      run_read(100, 0);
   endtask

   // Requests on every busy tick are ignored; back-to-back cycles, zero half period
   task automatic check_busy_requests();
      load_config(7'h00, 8'hFF, 8'd255, 16'd0);
      run_read(100, 100);
      run_read(100, 100);
   endtask

   // Zero retry limit acts as one clock; every poll fails
   task automatic check_poll_exhaust();
      load_config(7'h48, 8'h84, 8'd0, 16'd1);
      run_read(0, 0);
   endtask

   // Every poll repeats its clock up to a small limit, then gives up
   task automatic check_poll_retry();
      load_config(7'h55, 8'hAA, 8'd3, 16'd1);
      run_read(0, 0);
   endtask

   // Random configurations and read cycles with idle noise in between
   task automatic run_random_mix(input int tick_goal);
      int          first_tick;
      logic [7:0]  retry;
      logic [15:0] half;
      first_tick = n_ticks;
      while (n_ticks - first_tick < tick_goal) begin
         case ($urandom_range(0, 3))
            0:       retry = 8'd0;
            1:       retry = 8'd1;
            2:       retry = 8'($urandom_range(2, 5));
            default: retry = 8'($urandom_range(6, 255));
         endcase
         case ($urandom_range(0, 7))
            0:       half = 16'd0;
            6:       half = 16'd2;
            7:       half = 16'($urandom_range(3, 6));
            default: half = 16'd1;
         endcase
         load_config(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), retry, half);
         repeat ($urandom_range(0, 5)) send_tick(1'b0, 1'($urandom_range(0, 1)));
         run_read($urandom_range(20, 100), $urandom_range(0, 30));
      end
   endtask

   // Largest half period: hold the first start phase for a few dozen ticks
   task automatic check_long_phase();
      load_config(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd20, 16'hFFFF);
      send_tick(1'b1, 1'b0);
      repeat (LONG_PHASE_TICKS) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic field_check(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         n_errors++;
         if (n_errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Compare each result transfer with the oldest expectation; randomize stall
   always @(posedge clock) begin : line_checker
      i2cadc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               n_errors++;
               $display("%0t: result with none expected, expected nothing, actual %0h",
                        $time, {rsp_scl_level, rsp_sda_enable, rsp_sda_level});
            end else begin
               want = expected_lines.pop_front();
               field_check("scl_level", 16'(want.scl_level), 16'(rsp_scl_level));
               field_check("sda_enable", 16'(want.sda_enable), 16'(rsp_sda_enable));
               field_check("sda_level", 16'(want.sda_level), 16'(rsp_sda_level));
               field_check("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
               field_check("done_res", 16'(want.done_res), 16'(rsp_done_res));
               field_check("sample_word", want.sample_word, rsp_sample_word);
               field_check("readback_byte", 16'(want.readback_byte),
                           16'(rsp_readback_byte));
               field_check("ack_missing", 16'(want.ack_missing), 16'(rsp_ack_missing));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   // Hard stop if the run hangs
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_lines.size());
         $display("i2c_adc_read_sequencer_test: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles less than receiver
      tx_gap_pct = 36;
      rx_stall_pct = 49;
      check_idle_lines();
      check_clean_read();
      check_busy_requests();

      // receiver idles less than sender
      tx_gap_pct = 49;
      rx_stall_pct = 36;
      check_poll_exhaust();
      check_poll_retry();

      // full rate both ways
      tx_gap_pct = 0;
      rx_stall_pct = 0;
      run_random_mix(RANDOM_TICK_GOAL);
      check_long_phase();

      settle_pipeline();
      $display("Covered %0d bus ticks over %0d read cycles: %0d completions,",
               n_ticks, n_reads, n_done);
      $display("%0d polls out of retries, %0d mismatches seen.", n_exhausted, n_errors);
      if (n_errors == 0) begin
         $display("i2c_adc_read_sequencer_test: done, clean");
      end else begin
         $display("i2c_adc_read_sequencer_test: done, errors");
      end
      $finish;
   end

endmodule
